### design/pbnc_pkg.sv
// Package for the palette blend nearest-color block.
// Holds the widths, codes, the shared unit's operation type and small helper functions.
// No dependencies.
package pbnc_pkg;

  localparam int PAL_SIZE_DEF = 256;

  // Shared multiply-accumulate unit operand and accumulator widths.
  localparam int MAC_A_W   = 8;
  localparam int MAC_B_W   = 22;
  localparam int MAC_ACC_W = 32;

  // Blended channel sums reach 255 * 4096 at most.
  localparam int BLEND_W = 20;

  localparam int WEIGHT_W = 13;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 13'd4096;
  localparam logic [6:0]          PCT_FULL    = 7'd100;
  localparam logic [6:0]          PCT_RESET   = 7'd66;
  // ceil(2^22 / 25): (pct * 1024) / 25 equals (pct * WEIGHT_RECIP) >> 12 for pct <= 100.
  localparam logic [17:0]         WEIGHT_RECIP = 18'd167773;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic                      en;
    logic                      clr;
    logic [MAC_A_W-1:0]        a;
    logic signed [MAC_B_W-1:0] b;
  } pbnc_mac_op_t;

  // Front weight from the translucency percentage, saturated at one hundred.
  function automatic logic [WEIGHT_W-1:0] pbnc_weight(input logic [6:0] pct);
    logic [6:0]  p;
    logic [24:0] prod;
    p    = (pct > PCT_FULL) ? PCT_FULL : pct;
    prod = 25'(p) * 25'(WEIGHT_RECIP);
    return prod[24:12];
  endfunction

  // Palette entries pack red in the top byte, then green, then blue.
  function automatic logic [7:0] pbnc_chan(input logic [23:0] col, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      CH_RED:   v = col[23:16];
      CH_GREEN: v = col[15:8];
      CH_BLUE:  v = col[7:0];
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

### design/pbnc_mac.sv
// Shared multiply-accumulate unit: operand register, product register, accumulator.
// An issued operation passes the operand and product registers before it reaches the accumulator.
// Depends on pbnc_pkg.
module pbnc_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pbnc_pkg::pbnc_mac_op_t              op,
  output logic signed [pbnc_pkg::MAC_ACC_W-1:0] acc
);
  import pbnc_pkg::*;

  localparam int PROD_W = MAC_A_W + 1 + MAC_B_W;

  pbnc_mac_op_t               op_r;
  logic                       prod_en_r;
  logic                       prod_clr_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [MAC_ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r.en    <= 1'b0;
      op_r.clr   <= 1'b0;
      prod_en_r  <= 1'b0;
      prod_clr_r <= 1'b0;
    end else begin
      op_r.en    <= op.en;
      op_r.clr   <= op.clr;
      prod_en_r  <= op_r.en;
      prod_clr_r <= op_r.clr;
    end
    op_r.a <= op.a;
    op_r.b <= op.b;
    prod_r <= $signed({1'b0, op_r.a}) * op_r.b;
    if (prod_en_r) begin
      if (prod_clr_r) begin
        acc_r <= MAC_ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + MAC_ACC_W'(prod_r);
      end
    end
  end

  assign acc = acc_r;

endmodule

### design/palette_blend_nearest_color.sv
// Top level of the palette blend nearest-color block: palette memory, sequencer, output register.
// Depends on pbnc_pkg and pbnc_mac.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------------
//   in_     | input     | in_valid/in_stall   | mode, entry_index, red, green, blue, back_index,
//           |           |                    | front_index
//   out_    | output    | out_valid/out_stall | blend_index
//   cfg_    | input     | cfg_wr_en           | filter_pct
//
// A load beat is written into the palette at the accepting edge.
// A query beat is processed by the single multiply-accumulate unit, which works through every
// color channel of every palette entry in turn; the input is stalled while a query runs.
// Reset is synchronous and active low; it clears the sequencer and sets filter_pct to 66.
// The palette itself is not cleared and must be loaded before the first query.
// A finished result waits in the output register; the next beat is taken while it waits.
module palette_blend_nearest_color #(
  parameter int PALETTE_SIZE = pbnc_pkg::PAL_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_entry_index,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_back_index,
  input  logic [7:0] in_front_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blend_index,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_filter_pct
);
  import pbnc_pkg::*;

  localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);
  localparam logic [8:0]       SIZE_9   = 9'(PALETTE_SIZE);

  // Step counter milestones of the blend phase. The unit is fed front, back for red,
  // then green, then blue; each channel sum is ready once its back term is in the accumulator.
  localparam logic [3:0] STEP_OPS_END = 4'd6;
  localparam logic [3:0] STEP_M_RED   = 4'd4;
  localparam logic [3:0] STEP_M_GREEN = 4'd6;
  localparam logic [3:0] STEP_M_BLUE  = 4'd8;
  localparam logic [3:0] DRAIN_LAST   = 4'd2;
  localparam logic [1:0] PHASE_LAST   = CH_BLUE;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_BACK,
    S_RD_FRONT,
    S_BLEND,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t                       state_r;
  logic [3:0]                   step_r;
  logic [IDX_W-1:0]             ent_r;
  logic [1:0]                   phase_r;
  logic                         prev_vld_r;
  logic                         best_vld_r;
  logic signed [MAC_ACC_W-1:0]  best_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [7:0]                   back_idx_r;
  logic [7:0]                   front_idx_r;
  logic [23:0]                  back_col_r;
  logic [BLEND_W-1:0]           m_r [3];
  logic [WEIGHT_W-1:0]          weight_r;
  logic                         out_valid_r;
  logic [7:0]                   out_blend_index_r;

  // Palette memory with a registered read port.
  logic [23:0]                  mem [PALETTE_SIZE];
  logic [23:0]                  rdata_r;
  logic                         rd_zero_r;
  logic                         rd_en;
  logic                         rd_zero;
  logic [IDX_W-1:0]             rd_addr;

  logic                         in_take;
  logic                         load_ok;
  logic [WEIGHT_W-1:0]          weight_back;
  logic [23:0]                  front_col;
  logic [7:0]                   scan_chan;
  pbnc_mac_op_t                 mac_op;
  logic signed [MAC_ACC_W-1:0]  acc;
  logic                         cmp_en;
  logic [IDX_W-1:0]             cmp_idx;
  logic                         out_free;

  assign in_stall        = (state_r != S_IDLE);
  assign in_take         = in_valid && !in_stall;
  assign load_ok         = ({1'b0, in_entry_index} < SIZE_9);
  assign weight_back     = WEIGHT_FULL - weight_r;
  assign front_col       = rd_zero_r ? 24'd0 : rdata_r;
  assign scan_chan       = pbnc_chan(rdata_r, phase_r);
  assign out_free        = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_blend_index = out_blend_index_r;

  // Memory read requests: the two query colors, then one entry ahead of the scan.
  always_comb begin
    rd_en   = 1'b0;
    rd_zero = 1'b0;
    rd_addr = '0;
    case (state_r)
      S_RD_BACK: begin
        rd_en   = 1'b1;
        rd_addr = back_idx_r[IDX_W-1:0];
        rd_zero = ({1'b0, back_idx_r} >= SIZE_9);
      end
      S_RD_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = front_idx_r[IDX_W-1:0];
        rd_zero = ({1'b0, front_idx_r} >= SIZE_9);
      end
      S_BLEND: begin
        if (step_r == STEP_M_BLUE) begin
          rd_en   = 1'b1;
          rd_addr = LAST_IDX;
        end
      end
      S_SCAN: begin
        if (phase_r == PHASE_LAST && ent_r != '0) begin
          rd_en   = 1'b1;
          rd_addr = ent_r - IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take && in_mode == MODE_LOAD && load_ok) begin
      mem[in_entry_index[IDX_W-1:0]] <= {in_red, in_green, in_blue};
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_addr];
      rd_zero_r <= rd_zero;
    end
  end

  // Operations for the shared unit. During the blend it forms front*w1 + back*w2 per
  // channel; during the scan it forms c * (c*2048 - m) per channel of the current entry,
  // which sums to the entry's score.
  always_comb begin
    mac_op.en  = 1'b0;
    mac_op.clr = 1'b0;
    mac_op.a   = '0;
    mac_op.b   = '0;
    case (state_r)
      S_BLEND: begin
        if (step_r < STEP_OPS_END) begin
          mac_op.en = 1'b1;
          if (!step_r[0]) begin
            mac_op.clr = 1'b1;
            mac_op.a   = pbnc_chan(front_col, step_r[2:1]);
            mac_op.b   = MAC_B_W'(weight_r);
          end else begin
            mac_op.a   = pbnc_chan(back_col_r, step_r[2:1]);
            mac_op.b   = MAC_B_W'(weight_back);
          end
        end
      end
      S_SCAN: begin
        mac_op.en  = 1'b1;
        mac_op.clr = (phase_r == CH_RED);
        mac_op.a   = scan_chan;
        mac_op.b   = $signed({3'b000, scan_chan, 11'd0}) - $signed({2'b00, m_r[phase_r]});
      end
      default: begin
      end
    endcase
  end

  pbnc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .acc   (acc)
  );

  // The score of an entry is complete during the last channel cycle of the entry below it,
  // or during the last drain cycle for entry zero.
  always_comb begin
    cmp_en  = 1'b0;
    cmp_idx = '0;
    if (state_r == S_SCAN && phase_r == PHASE_LAST && prev_vld_r) begin
      cmp_en  = 1'b1;
      cmp_idx = ent_r + IDX_W'(1);
    end else if (state_r == S_DRAIN && step_r == DRAIN_LAST) begin
      cmp_en  = 1'b1;
    end
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      ent_r       <= '0;
      phase_r     <= CH_RED;
      prev_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      weight_r    <= pbnc_weight(PCT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        weight_r <= pbnc_weight(cfg_filter_pct);
      end
      // A beat leaving the output register is replaced in the same cycle when a result is
      // ready, so the clear only applies outside the output state.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      // Scan downward with a strict compare: among equal scores the higher index stays.
      if (cmp_en && (!best_vld_r || acc < best_r)) begin
        best_vld_r <= 1'b1;
        best_r     <= acc;
        best_idx_r <= cmp_idx;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take && in_mode == MODE_QUERY) begin
            back_idx_r  <= in_back_index;
            front_idx_r <= in_front_index;
            state_r     <= S_RD_BACK;
          end
        end
        S_RD_BACK: begin
          state_r <= S_RD_FRONT;
        end
        S_RD_FRONT: begin
          back_col_r <= rd_zero_r ? 24'd0 : rdata_r;
          step_r     <= '0;
          state_r    <= S_BLEND;
        end
        S_BLEND: begin
          step_r <= step_r + 4'd1;
          if (step_r == STEP_M_RED) begin
            m_r[0] <= acc[BLEND_W-1:0];
          end
          if (step_r == STEP_M_GREEN) begin
            m_r[1] <= acc[BLEND_W-1:0];
          end
          if (step_r == STEP_M_BLUE) begin
            m_r[2]     <= acc[BLEND_W-1:0];
            ent_r      <= LAST_IDX;
            phase_r    <= CH_RED;
            prev_vld_r <= 1'b0;
            best_vld_r <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (phase_r == PHASE_LAST) begin
            phase_r    <= CH_RED;
            prev_vld_r <= 1'b1;
            if (ent_r == '0) begin
              step_r  <= '0;
              state_r <= S_DRAIN;
            end else begin
              ent_r <= ent_r - IDX_W'(1);
            end
          end else begin
            phase_r <= phase_r + 2'd1;
          end
        end
        S_DRAIN: begin
          step_r <= step_r + 4'd1;
          if (step_r == DRAIN_LAST) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_blend_index_r <= 8'(best_idx_r);
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A query beat starts the memory reads right away.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_mode == MODE_QUERY) |=> (state_r == S_RD_BACK))
    else $error("query beat did not start the color reads");

  // The channel phase never leaves the three color channels while scanning.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (phase_r == CH_RED || phase_r == CH_GREEN || phase_r == CH_BLUE))
    else $error("scan phase out of range");

  // The last channel of entry zero hands over to the drain.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && phase_r == PHASE_LAST && ent_r == '0) |=> (state_r == S_DRAIN))
    else $error("scan did not end after entry zero");

  // A finished query with a free output slot shows its result and frees the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE && best_vld_r))
    else $error("finished query lost its result");

endmodule

### test/palette_blend_nearest_color_test.sv
// Self-checking testbench for palette_blend_nearest_color: palette loads, blend queries and
// filter percentage writes, checked beat by beat against typed expectations or a behavioral predictor.
// Depends on pbnc_pkg and on the palette_blend_nearest_color RTL; needs nothing else.
`timescale 1ns / 1ps

module palette_blend_nearest_color_test;
  import pbnc_pkg::*;

  // Clock, reset and run-length settings.
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int PAL_ENTRIES   = PAL_SIZE_DEF;
  // A load leaves nothing in flight once it is taken; this margin is ample before a register write.
  localparam int SETTLE_CYCLES = 32;
  // One query scans three channels per entry plus some overhead.
  localparam int TAIL_CYCLES   = 3 * PAL_ENTRIES + 32;
  localparam int DRAIN_LIMIT   = 8 * TAIL_CYCLES;
  localparam int HOLD_CYCLES   = 3000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 170;
  localparam int TIMEOUT_NS    = 80_000_000;

  // Weight arithmetic of the blend: 12 fractional bits, squared norm scaled by half a unit.
  localparam longint WEIGHT_ONE  = longint'(WEIGHT_FULL);
  localparam longint PCT_CAP     = longint'(PCT_FULL);
  localparam longint NORM_SCALE  = WEIGHT_ONE / 2;
  localparam longint SCORE_WORST = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    bit [7:0] r;
    bit [7:0] g;
    bit [7:0] b;
  } color_t;

  typedef struct packed {
    bit       mode;
    bit [7:0] entry_index;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] back_index;
    bit [7:0] front_index;
  } in_beat_t;

  typedef enum bit {STEP_BEAT, STEP_CFG} step_kind_t;

  // One row of the directed table: either an input beat or a register write.
  typedef struct {
    step_kind_t kind;
    in_beat_t   beat;
    bit         typed;
    bit [7:0]   want;
    bit [6:0]   pct;
  } step_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_mode;
  logic [7:0] in_entry_index;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_back_index;
  logic [7:0] in_front_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_blend_index;
  logic       cfg_wr_en;
  logic [6:0] cfg_filter_pct;

  // Our own copy of the block's state: the palette and the filter percentage.
  color_t   shadow_palette [PAL_ENTRIES];
  bit [6:0] shadow_pct = PCT_RESET;

  // Expected blend indexes, oldest first.
  bit [7:0] pending_blend [$];

  // Flags shared between the sender, the receiver and the sequencing code.
  bit source_quiet = 1'b0;
  bit sink_quiet   = 1'b0;
  bit hold_request = 1'b0;
  int holds_done   = 0;
  int fail_count   = 0;
  int load_count   = 0;
  int query_count  = 0;
  int cfg_count    = 0;

  palette_blend_nearest_color dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_back_index  (in_back_index),
    .in_front_index (in_front_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blend_index(out_blend_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_filter_pct (cfg_filter_pct)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Blend the back and front entries with the current percentage, then scan the palette
  // from the top index down. The strict compare keeps the higher index on a tie.
  function automatic bit [7:0] nearest_blend(input bit [7:0] back_i, input bit [7:0] front_i);
    longint pct_sat;
    longint front_w;
    longint back_w;
    longint mix_r;
    longint mix_g;
    longint mix_b;
    longint cr;
    longint cg;
    longint cb;
    longint score;
    longint best;
    bit [7:0] pick;
    pct_sat = (longint'(shadow_pct) > PCT_CAP) ? PCT_CAP : longint'(shadow_pct);
    front_w = (pct_sat * WEIGHT_ONE) / PCT_CAP;
    back_w  = WEIGHT_ONE - front_w;
    mix_r = longint'(shadow_palette[front_i].r) * front_w
          + longint'(shadow_palette[back_i].r) * back_w;
    mix_g = longint'(shadow_palette[front_i].g) * front_w
          + longint'(shadow_palette[back_i].g) * back_w;
    mix_b = longint'(shadow_palette[front_i].b) * front_w
          + longint'(shadow_palette[back_i].b) * back_w;
    best = SCORE_WORST;
    pick = 8'd0;
    for (int c = PAL_ENTRIES - 1; c >= 0; c--) begin
      cr = longint'(shadow_palette[c].r);
      cg = longint'(shadow_palette[c].g);
      cb = longint'(shadow_palette[c].b);
      score = (cr * cr + cg * cg + cb * cb) * NORM_SCALE - cr * mix_r - cg * mix_g - cb * mix_b;
      if (score < best) begin
        best = score;
        pick = 8'(c);
      end
    end
    return pick;
  endfunction

  // Half of the colors are fully random. The rest are saturated corners or copies of an
  // entry already in the palette, sometimes off by one in blue, so that ties and near ties
  // show up in the scan.
  function automatic color_t random_color();
    color_t c;
    int     pick;
    pick = $urandom_range(0, 9);
    c = 24'($urandom);
    if (pick >= 5 && pick < 7) begin
      c.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      c.g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      c.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (pick >= 7) begin
      c = shadow_palette[$urandom_range(0, PAL_ENTRIES - 1)];
      if (pick == 9) begin
        c.b = c.b ^ 8'h01;
      end
    end
    return c;
  endfunction

  function automatic step_t load_step(input bit [7:0] idx, input bit [7:0] r,
                                      input bit [7:0] g, input bit [7:0] b);
    step_t s;
    s = '{kind: STEP_BEAT, beat: '0, typed: 1'b0, want: 8'd0, pct: 7'd0};
    s.beat.mode        = MODE_LOAD;
    s.beat.entry_index = idx;
    s.beat.red         = r;
    s.beat.green       = g;
    s.beat.blue        = b;
    return s;
  endfunction

  function automatic step_t query_step(input bit [7:0] back_i, input bit [7:0] front_i,
                                       input bit typed, input bit [7:0] want);
    step_t s;
    s = '{kind: STEP_BEAT, beat: '0, typed: typed, want: want, pct: 7'd0};
    s.beat.mode        = MODE_QUERY;
    s.beat.back_index  = back_i;
    s.beat.front_index = front_i;
    return s;
  endfunction

  function automatic step_t cfg_step(input bit [6:0] pct);
    step_t s;
    s = '{kind: STEP_CFG, beat: '0, typed: 1'b0, want: 8'd0, pct: pct};
    return s;
  endfunction

  // Offer one input beat and hold it until the block takes it. The fields that the beat's
  // mode does not use are filled with noise. At the accepting edge the shadow state is
  // updated and, for a query, the expected blend index is queued. A typed expectation from
  // the directed table takes the place of the predictor.
  task automatic send_beat(input in_beat_t b, input bit typed, input bit [7:0] want);
    int gap;
    gap = source_quiet ? 0 : $urandom_range(0, 14);
    if (b.mode == MODE_LOAD) begin
      b.back_index  = 8'($urandom);
      b.front_index = 8'($urandom);
    end else begin
      b.entry_index = 8'($urandom);
      b.red         = 8'($urandom);
      b.green       = 8'($urandom);
      b.blue        = 8'($urandom);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= b.mode;
    in_entry_index <= b.entry_index;
    in_red         <= b.red;
    in_green       <= b.green;
    in_blue        <= b.blue;
    in_back_index  <= b.back_index;
    in_front_index <= b.front_index;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (b.mode == MODE_LOAD) begin
      shadow_palette[b.entry_index] = {b.red, b.green, b.blue};
      load_count++;
    end else begin
      pending_blend.push_back(typed ? want : nearest_blend(b.back_index, b.front_index));
      query_count++;
    end
  endtask

  // Stop offering beats and wait for every outstanding blend result. The queue is checked
  // only after the clock has risen, so a beat offered right afterwards never meets the lowering of valid.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_blend.size() != 0);
  endtask

  // The percentage register is only written with the block idle.
  task automatic set_filter(input bit [6:0] pct);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_filter_pct <= pct;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    shadow_pct = pct;
    cfg_count++;
  endtask

  // Result side: before every beat it stalls for a random number of cycles, then keeps
  // stall low until a beat arrives and checks it against the oldest expectation. When the
  // sequencing code asks for it, it holds stall high for a long stretch so the output
  // register fills and the block has to stall its input.
  initial begin : result_sink
    int       stall_n;
    bit [7:0] want;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall_n = sink_quiet ? 0 : $urandom_range(0, 14);
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_blend.size() == 0) begin
        $error("blend_index: beat with no expectation waiting, expected none, actual %0d",
               out_blend_index);
        fail_count++;
      end else begin
        want = pending_blend.pop_front();
        if (out_blend_index !== want) begin
          $error("blend_index mismatch: expected %0d, actual %0d", want, out_blend_index);
          fail_count++;
        end
      end
    end
  end

  // Sequencing: reset, a black palette, the directed table, then random phases, each with
  // its own filter percentage.
  initial begin : stimulus
    step_t    directed [$];
    in_beat_t b;
    color_t   c;
    bit [6:0] pct;
    int       phase;
    int       n;
    int       i;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_LOAD;
    in_entry_index <= 8'd0;
    in_red         <= 8'd0;
    in_green       <= 8'd0;
    in_blue        <= 8'd0;
    in_back_index  <= 8'd0;
    in_front_index <= 8'd0;
    cfg_wr_en      <= 1'b0;
    cfg_filter_pct <= PCT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The palette is undefined after reset, so every entry is written black before the
    // first query. With all entries equal, every score ties and the top index must win.
    for (i = 0; i < PAL_ENTRIES; i++) begin
      b = '0;
      b.mode        = MODE_LOAD;
      b.entry_index = 8'(i);
      send_beat(b, 1'b0, 8'd0);
    end

    // Directed part. Expected indexes are typed in only where they follow from a glance:
    // a single matching color, a tie among identical colors, or a weight of zero or full.
    // Rows with a real blend go through the predictor. The first rows run with the
    // percentage left at its reset value.
    directed = '{
      query_step(8'd0,   8'd0,   1'b1, 8'd255),   // all black: tie resolves to the top
      query_step(8'd255, 8'd128, 1'b1, 8'd255),
      load_step (8'd3,   8'hFF, 8'hFF, 8'hFF),
      query_step(8'd3,   8'd3,   1'b1, 8'd3),     // the only white entry
      load_step (8'd255, 8'hFF, 8'hFF, 8'hFF),
      query_step(8'd3,   8'd3,   1'b1, 8'd255),   // two whites: the higher index wins
      query_step(8'd0,   8'd255, 1'b0, 8'd0),
      load_step (8'd0,   8'hFF, 8'h00, 8'h00),
      load_step (8'd1,   8'h00, 8'hFF, 8'h00),
      load_step (8'd2,   8'h00, 8'h00, 8'hFF),
      query_step(8'd1,   8'd2,   1'b0, 8'd0),     // green and blue at the reset percentage
      cfg_step  (7'd0),
      query_step(8'd3,   8'd0,   1'b1, 8'd255),   // back color only: white
      query_step(8'd0,   8'd3,   1'b1, 8'd0),     // back color only: red
      cfg_step  (7'd100),
      query_step(8'd3,   8'd0,   1'b1, 8'd0),     // front color only: red
      query_step(8'd0,   8'd1,   1'b1, 8'd1),     // front color only: green
      cfg_step  (7'd127),                         // saturates to one hundred
      query_step(8'd2,   8'd1,   1'b1, 8'd1),
      query_step(8'd1,   8'd2,   1'b1, 8'd2),
      cfg_step  (7'd50),
      query_step(8'd0,   8'd1,   1'b0, 8'd0),
      load_step (8'd128, 8'h80, 8'h80, 8'h80),
      query_step(8'd255, 8'd0,   1'b0, 8'd0)
    };
    foreach (directed[i]) begin
      if (directed[i].kind == STEP_CFG) begin
        set_filter(directed[i].pct);
      end else begin
        send_beat(directed[i].beat, directed[i].typed, directed[i].want);
      end
    end

    // Random part. Phase 0 first repaints the whole palette with random colors; every phase
    // mixes loads and queries. Phases 1 and 4 open with a stretch where neither side idles.
    // Phase 2 opens with a long output hold-off while beats keep coming. Phase 1 has a fixed
    // point, and any phase may have random ones, where the sender waits for every result.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        1:       pct = 7'd0;
        2:       pct = 7'd100;
        3:       pct = 7'd127;
        default: pct = 7'($urandom_range(0, 127));
      endcase
      set_filter(pct);
      source_quiet = (phase == 1) || (phase == 4);
      sink_quiet   = source_quiet;
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      if (phase == 0) begin
        for (i = 0; i < PAL_ENTRIES; i++) begin
          c = random_color();
          b = '0;
          b.mode        = MODE_LOAD;
          b.entry_index = 8'(i);
          b.red         = c.r;
          b.green       = c.g;
          b.blue        = c.b;
          send_beat(b, 1'b0, 8'd0);
        end
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 50) begin
          source_quiet = 1'b0;
          sink_quiet   = 1'b0;
        end
        if ((phase == 1 && n == 85) || $urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        b = '0;
        if ($urandom_range(0, 99) < 45) begin
          b.mode        = MODE_QUERY;
          b.back_index  = 8'($urandom);
          b.front_index = ($urandom_range(0, 4) == 0) ? b.back_index : 8'($urandom);
        end else begin
          c = random_color();
          b.mode        = MODE_LOAD;
          b.entry_index = 8'($urandom);
          b.red         = c.r;
          b.green       = c.g;
          b.blue        = c.b;
        end
        send_beat(b, 1'b0, 8'd0);
      end
    end

    // Wind down: wait for the last results, then let the clock run on for TAIL_CYCLES
    // so that any stray beat would still be caught by the result side.
    in_valid <= 1'b0;
    for (i = 0; i < DRAIN_LIMIT && pending_blend.size() != 0; i++) begin
      @(posedge clk);
    end
    if (pending_blend.size() != 0) begin
      $error("blend_index: expected %0d more beats, actual none arrived", pending_blend.size());
      fail_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d palette loads and %0d blend queries over %0d filter settings.",
             load_count, query_count, cfg_count);
    $display("Summary: %0d output hold-offs of %0d cycles, %0d checking errors.",
             holds_done, HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### palette_blend_nearest_color.f
design/pbnc_pkg.sv
design/pbnc_mac.sv
design/palette_blend_nearest_color.sv
test/palette_blend_nearest_color_test.sv
